// ===== src/variable_partition_allocator_unit_defines.svh =====
// assertion macros for the partition allocator
// no dependencies
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
// property that must hold at every edge outside reset
`define VPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication: the consequent must hold in the cycle after the antecedent
`define VPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/vpa_pkg.sv =====
// shared types, constants and codes for the partition allocator
// no dependencies
`timescale 1ns / 1ps
package vpa_pkg;
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int MEM_BYTES_DEF  = 1048576;
    localparam int OWNER_BITS_DEF = 8;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2, ST_ZERO = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0, POL_BEST = 2'd1, POL_WORST = 2'd2, POL_RSVD = 2'd3
    } t_policy;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [0:0] REG_FIT_POLICY = 1'd0;

    typedef struct packed {
        logic        mode;
        logic [7:0]  owner_id;
        logic [20:0] request_size;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] block_address;
        logic [5:0]  entries_used;
    } t_out_word;

    // commands broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD, CMD_RELEASE, CMD_SPLIT, CMD_CLAIM, CMD_MERGE
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RELEASE, S_MERGE, S_DONE
    } t_state;
endpackage

// ===== src/vpa_cell.sv =====
// one table entry: start, size, free mark, owner; shifts with its neighbors
// depends on vpa_pkg
`timescale 1ns / 1ps
module vpa_cell import vpa_pkg::*; #(
    parameter int AW = 21,
    parameter int OW = 8,
    parameter int IW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_index,
    input  logic          i_reset_free,
    input  logic [AW-1:0] i_reset_size,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_sel,
    input  logic [AW-1:0] i_need,
    input  logic [OW-1:0] i_owner,
    // left neighbor entry (index-1)
    input  logic [AW-1:0] i_prev_start,
    input  logic [AW-1:0] i_prev_size,
    input  logic          i_prev_free,
    input  logic [OW-1:0] i_prev_owner,
    // right neighbor entry (index+1)
    input  logic [AW-1:0] i_next_start,
    input  logic [AW-1:0] i_next_size,
    input  logic          i_next_free,
    input  logic [OW-1:0] i_next_owner,
    output logic [AW-1:0] o_start,
    output logic [AW-1:0] o_size,
    output logic          o_free,
    output logic [OW-1:0] o_owner
);
    logic [AW-1:0] r_start, n_start, r_size, n_size;
    logic          r_free, n_free;
    logic [OW-1:0] r_owner, n_owner;

    // entry update for the broadcast command
    always_comb begin
        n_start = r_start;
        n_size  = r_size;
        n_free  = r_free;
        n_owner = r_owner;
        case (i_cmd)
            CMD_RELEASE: begin
                if (!r_free && r_owner == i_owner) begin
                    n_free  = 1'b1;
                    n_owner = '0;
                end
            end
            CMD_CLAIM: begin
                if (i_index == i_sel) begin
                    n_free  = 1'b0;
                    n_owner = i_owner;
                end
            end
            CMD_SPLIT: begin
                if (i_index == i_sel) begin
                    n_size  = i_need;
                    n_free  = 1'b0;
                    n_owner = i_owner;
                end else if (i_index == i_sel + 1'b1) begin
                    n_start = i_prev_start + i_need;
                    n_size  = i_prev_size - i_need;
                    n_free  = 1'b1;
                    n_owner = '0;
                end else if (i_index > i_sel) begin
                    n_start = i_prev_start;
                    n_size  = i_prev_size;
                    n_free  = i_prev_free;
                    n_owner = i_prev_owner;
                end
            end
            CMD_MERGE: begin
                if (i_index == i_sel) begin
                    n_size = r_size + i_next_size;
                end else if (i_index > i_sel) begin
                    n_start = i_next_start;
                    n_size  = i_next_size;
                    n_free  = i_next_free;
                    n_owner = i_next_owner;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_size  <= i_reset_size;
            r_free  <= i_reset_free;
            r_owner <= '0;
        end else begin
            r_start <= n_start;
            r_size  <= n_size;
            r_free  <= n_free;
            r_owner <= n_owner;
        end
    end

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_free  = r_free;
    assign o_owner = r_owner;
endmodule

// ===== src/variable_partition_allocator_unit.sv =====
// Partition allocator: a row of MAX_BLOCKS table cells plus a sequencer, one request
// at a time. An allocate scans one entry per cycle (first fit stops at the first
// fitting entry), then passes a decide state that updates the row on a grant, then a
// result state, after which the result word is valid. A free passes a release state,
// then a merge walk that steps through the table positions and merges adjacent free
// entries, then the result state. A zero size request goes from idle straight to the
// result state, and a free of an unknown owner goes there from the release state. The
// next request is accepted from the cycle after the result word is taken.
// depends on vpa_pkg, vpa_cell and the defines header
`timescale 1ns / 1ps
`include "variable_partition_allocator_unit_defines.svh"
module variable_partition_allocator_unit import vpa_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int MEM_BYTES  = MEM_BYTES_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = ($clog2(MEM_BYTES + 1) > 21) ? $clog2(MEM_BYTES + 1) : 21;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam int OW_L = OWNER_BITS;

    logic [AW-1:0] c_start [MAX_BLOCKS];
    logic [AW-1:0] c_size  [MAX_BLOCKS];
    logic          c_free  [MAX_BLOCKS];
    logic [OW_L-1:0] c_owner [MAX_BLOCKS];

    t_state r_state, n_state;
    logic [1:0] r_policy;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_sel, n_sel;
    logic          r_found, n_found;
    logic [AW-1:0] r_bsize, n_bsize;
    logic          r_mode;
    logic [OW_L-1:0] r_own;
    logic [AW-1:0] r_need;
    logic          r_big;
    logic [1:0]    r_status, n_status;
    logic [19:0]   r_addr, n_addr;
    logic          r_ovalid;
    t_cmd          cmd;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FIT_POLICY) ? {30'd0, r_policy} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_policy <= POL_FIRST;
        else if (psel && penable && pwrite && paddr == REG_FIT_POLICY)
            r_policy <= pwdata[1:0];
    end

    // row of cells
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        localparam int GP = (g == 0) ? 0 : g - 1;
        localparam int GN = (g == MAX_BLOCKS - 1) ? g : g + 1;
        vpa_cell #(.AW(AW), .OW(OW_L), .IW(IW)) u_cell (
            .i_clk, .i_rst_n,
            .i_index(IW'(g)), .i_reset_free(g == 0),
            .i_reset_size(g == 0 ? AW'(MEM_BYTES) : AW'(0)),
            .i_cmd(cmd), .i_sel(r_sel), .i_need(r_need), .i_owner(r_own),
            .i_prev_start(c_start[GP]), .i_prev_size(g == 0 ? AW'(0) : c_size[GP]),
            .i_prev_free(c_free[GP]), .i_prev_owner(c_owner[GP]),
            .i_next_start(c_start[GN]),
            .i_next_size(g == MAX_BLOCKS - 1 ? AW'(0) : c_size[GN]),
            .i_next_free(g == MAX_BLOCKS - 1 ? 1'b0 : c_free[GN]),
            .i_next_owner(g == MAX_BLOCKS - 1 ? OW_L'(0) : c_owner[GN]),
            .o_start(c_start[g]), .o_size(c_size[g]),
            .o_free(c_free[g]), .o_owner(c_owner[g])
        );
    end

    // hold off the first request word right after reset, until r_init clears
    logic r_init;

    logic [AW-1:0] s_size;
    logic          s_free, s_fit, s_take, scan_last, m_last;
    assign s_size = c_size[r_idx];
    assign s_free = c_free[r_idx];
    assign s_fit  = s_free && (s_size >= r_need);
    assign scan_last = ({1'b0, r_idx} + 1'b1) >= {1'b0, r_count};
    assign m_last    = ({1'b0, r_idx} + 2'd2) > {1'b0, r_count};
    always_comb begin
        unique case (r_policy)
            POL_BEST:  s_take = s_fit && (!r_found || s_size < r_bsize);
            POL_WORST: s_take = s_fit && (!r_found || s_size > r_bsize);
            default:   s_take = s_fit && !r_found;
        endcase
    end

    // any cell owned by the freed id
    logic any_own;
    always_comb begin
        any_own = 1'b0;
        for (int k = 0; k < MAX_BLOCKS; k++)
            if (CW'(k) < r_count && !c_free[k] && c_owner[k] == r_own) any_own = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid && o_ready) begin
                           if (i_data.mode == MODE_FREE) n_state = S_RELEASE;
                           else if (i_data.request_size == '0) n_state = S_DONE;
                           else n_state = S_SCAN;
                       end
            S_SCAN:    if (scan_last || (r_policy != POL_BEST && r_policy != POL_WORST
                                         && s_fit)) n_state = S_DECIDE;
            S_DECIDE:  n_state = S_DONE;
            S_RELEASE: n_state = any_own ? S_MERGE : S_DONE;
            S_MERGE:   if (m_last) n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and cell commands
    always_comb begin
        cmd = CMD_HOLD;
        n_idx = r_idx; n_sel = r_sel; n_found = r_found; n_bsize = r_bsize;
        n_count = r_count; n_status = r_status; n_addr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0; n_found = 1'b0; n_sel = '0;
                if (i_valid && o_ready) begin
                    n_status = ST_OK; n_addr = '0;
                    if (i_data.mode == MODE_ALLOC && i_data.request_size == '0)
                        n_status = ST_ZERO;
                end
            end
            S_SCAN: begin
                if (s_take) begin
                    n_found = 1'b1; n_sel = r_idx; n_bsize = s_size;
                end
                if (!scan_last) n_idx = r_idx + 1'b1;
            end
            S_DECIDE: begin
                if (r_big || !r_found) n_status = ST_MISS;
                else if (r_bsize > r_need && r_count >= MAXC) n_status = ST_FULL;
                else begin
                    n_addr = 20'(c_start[r_sel]);
                    if (r_bsize > r_need) begin
                        cmd = CMD_SPLIT;
                        n_count = r_count + 1'b1;
                    end else cmd = CMD_CLAIM;
                end
            end
            S_RELEASE: begin
                cmd = CMD_RELEASE;
                n_idx = '0;
                n_sel = '0;
                if (!any_own) n_status = ST_MISS;
            end
            S_MERGE: begin
                if (!m_last) begin
                    if (c_free[r_idx] && c_free[r_idx + 1'b1]) begin
                        cmd = CMD_MERGE; n_sel = r_idx;
                        n_count = r_count - 1'b1;
                    end else n_idx = r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= CW'(1); r_ovalid <= 1'b0; r_init <= 1'b1;
            r_idx <= '0; r_sel <= '0; r_found <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count;
            r_idx <= n_idx; r_found <= n_found; r_init <= 1'b0;
            r_sel <= (r_state == S_MERGE) ? n_idx : n_sel;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (o_valid && i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bsize <= n_bsize; r_status <= n_status; r_addr <= n_addr;
        if (r_state == S_IDLE) begin
            r_mode <= i_data.mode;
            r_own  <= OW_L'(i_data.owner_id);
            r_need <= AW'(i_data.request_size);
            r_big  <= 1'b0;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid && !r_init;
    assign o_valid = r_ovalid;
    assign o_data.status = r_status;
    assign o_data.block_address = r_status == ST_OK ? r_addr : 20'd0;
    assign o_data.entries_used = 6'(r_count);

    `VPA_ASSERT(a_count_range, i_clk, i_rst_n, r_count >= CW'(1) && r_count <= MAXC,
        "entry count out of range")
    `VPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid,
        "result word dropped")
    `VPA_ASSERT(a_busy_ready, i_clk, i_rst_n, !(o_ready && r_mode && r_state != S_IDLE),
        "ready while busy")
endmodule

// ===== dv/variable_partition_allocator_unit_tb.sv =====
// testbench for the partition allocator: directed and random requests over all fit policies
// checks each result word against an in-bench block table predictor; depends on vpa_pkg and the DUT
`timescale 1ns / 1ps
module variable_partition_allocator_unit_tb;
    import vpa_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int MEM_SIZE    = 1048576;
    localparam int SETTLE_CYC  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_word    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_word   o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predicted block table
    int unsigned blk_start [TABLE_DEPTH];
    int unsigned blk_size  [TABLE_DEPTH];
    bit          blk_free  [TABLE_DEPTH];
    bit [7:0]    blk_owner [TABLE_DEPTH];
    int unsigned blk_count;
    t_policy     cur_policy;

    t_out_word   pending_results[$];
    int          fail_count;
    bit          no_idle;

    variable_partition_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // append a predicted word to the expected queue
    function automatic void queue_expect(t_out_word w);
        pending_results = {pending_results, w};
    endfunction

    // merge adjacent free runs of the predicted table
    function automatic void merge_free_runs();
        int unsigned i;
        i = 0;
        while (i + 1 < blk_count) begin
            if (blk_free[i] && blk_free[i + 1]) begin
                blk_size[i] += blk_size[i + 1];
                for (int unsigned j = i + 1; j + 1 < blk_count; j++) begin
                    blk_start[j] = blk_start[j + 1];
                    blk_size[j]  = blk_size[j + 1];
                    blk_free[j]  = blk_free[j + 1];
                    blk_owner[j] = blk_owner[j + 1];
                end
                blk_count--;
            end else begin
                i++;
            end
        end
    endfunction

    // apply one request to the predicted table and return the result word
    function automatic t_out_word apply_request(t_in_word w);
        t_out_word   r;
        int          sel;
        bit          hit;
        int unsigned need;
        need = w.request_size;
        r.status = ST_OK;
        r.block_address = '0;
        hit = 1'b0;
        sel = -1;
        if (w.mode == MODE_FREE) begin
            for (int unsigned i = 0; i < blk_count; i++) begin
                if (!blk_free[i] && blk_owner[i] == w.owner_id) begin
                    blk_free[i]  = 1'b1;
                    blk_owner[i] = '0;
                    hit = 1'b1;
                end
            end
            if (hit) merge_free_runs();
            else r.status = ST_MISS;
        end else if (need == 0) begin
            r.status = ST_ZERO;
        end else begin
            for (int i = 0; i < blk_count; i++) begin
                if (blk_free[i] && blk_size[i] >= need) begin
                    if (cur_policy == POL_BEST) begin
                        if (sel < 0 || blk_size[i] < blk_size[sel]) sel = i;
                    end else if (cur_policy == POL_WORST) begin
                        if (sel < 0 || blk_size[i] > blk_size[sel]) sel = i;
                    end else if (sel < 0) begin
                        sel = i;
                    end
                end
            end
            if (sel < 0) begin
                r.status = ST_MISS;
            end else if (blk_size[sel] > need && blk_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (blk_size[sel] > need) begin
                    for (int j = blk_count; j > sel + 1; j--) begin
                        blk_start[j] = blk_start[j - 1];
                        blk_size[j]  = blk_size[j - 1];
                        blk_free[j]  = blk_free[j - 1];
                        blk_owner[j] = blk_owner[j - 1];
                    end
                    blk_start[sel + 1] = blk_start[sel] + need;
                    blk_size[sel + 1]  = blk_size[sel] - need;
                    blk_free[sel + 1]  = 1'b1;
                    blk_owner[sel + 1] = '0;
                    blk_count++;
                    blk_size[sel] = need;
                end
                blk_free[sel]  = 1'b0;
                blk_owner[sel] = w.owner_id;
                r.block_address = blk_start[sel][19:0];
            end
        end
        r.entries_used = blk_count[5:0];
        return r;
    endfunction

    // send one word, with a random gap first unless no_idle is set, and record its prediction on accept
    task automatic send_word(input t_in_word w);
        if (!no_idle) begin
            while ($urandom_range(99) < 21) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        queue_expect(apply_request(w));
    endtask

    task automatic send_req(input logic m, input logic [7:0] own, input logic [20:0] sz);
        t_in_word w;
        w.mode = m;
        w.owner_id = own;
        w.request_size = sz;
        send_word(w);
    endtask

    // wait until the block is idle, then write the fit policy register
    task automatic write_policy(input logic [1:0] value);
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_FIT_POLICY;
        pwdata  <= {30'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_policy = t_policy'(value);
    endtask

    // zero size, oversize, field extremes, missing owner
    task automatic test_edge_cases();
        send_req(MODE_ALLOC, 8'h00, 21'd0);
        send_req(MODE_ALLOC, 8'hff, 21'h1fffff);
        send_req(MODE_ALLOC, 8'h5a, 21'd1048577);
        send_req(MODE_FREE,  8'h33, 21'd0);
        send_req(MODE_ALLOC, 8'hff, 21'd1);
        send_req(MODE_ALLOC, 8'h00, 21'd1048575);
        send_req(MODE_FREE,  8'h00, 21'h1fffff);
        send_req(MODE_FREE,  8'hff, 21'd0);
        send_req(MODE_ALLOC, 8'ha5, 21'd1048576);
        send_req(MODE_FREE,  8'ha5, 21'd7);
    endtask

    // fill the table, hit the full case, then an exact fit while full
    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH - 1; i++) send_req(MODE_ALLOC, 8'h01, 21'd16);
        send_req(MODE_ALLOC, 8'h02, 21'd16);
        send_req(MODE_ALLOC, 8'h02, 21'(MEM_SIZE - 16 * (TABLE_DEPTH - 1)));
        send_req(MODE_FREE,  8'h01, 21'd0);
        send_req(MODE_FREE,  8'h02, 21'd0);
    endtask

    // holes of different sizes so first, best and worst fit each pick a different one
    task automatic test_policy_choice();
        send_req(MODE_ALLOC, 8'h10, 21'd100);
        send_req(MODE_ALLOC, 8'h11, 21'd300);
        send_req(MODE_ALLOC, 8'h10, 21'd100);
        send_req(MODE_ALLOC, 8'h12, 21'd50);
        send_req(MODE_ALLOC, 8'h10, 21'd100);
        send_req(MODE_FREE,  8'h11, 21'd0);
        send_req(MODE_FREE,  8'h12, 21'd0);
        send_req(MODE_ALLOC, 8'h13, 21'd40);
        send_req(MODE_FREE,  8'h13, 21'd0);
        send_req(MODE_FREE,  8'h10, 21'd0);
    endtask

    // random requests: mostly small allocations and frees of a few owners
    task automatic test_random(input int count);
        logic [7:0]  own;
        logic [20:0] sz;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            if (n % 250 == 100) no_idle = 1'b1;
            if (n % 250 == 160) no_idle = 1'b0;
            pick = $urandom_range(99);
            own  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            if (pick < 55) sz = 21'($urandom_range(4096, 1));
            else if (pick < 63) sz = 21'($urandom_range(MEM_SIZE, 65536));
            else if (pick < 66) sz = 21'($urandom);
            else if (pick < 68) sz = 21'd0;
            else sz = 21'($urandom);
            send_req((pick >= 68) ? MODE_FREE : MODE_ALLOC, own, sz);
        end
    endtask

    // stall on the result side
    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", o_data);
                fail_count++;
            end else begin
                exp_w = pending_results.pop_front();
                if (o_data.status !== exp_w.status) begin
                    $error("status expected %0d actual %0d", exp_w.status, o_data.status);
                    fail_count++;
                end
                if (o_data.block_address !== exp_w.block_address) begin
                    $error("block_address expected %h actual %h",
                           exp_w.block_address, o_data.block_address);
                    fail_count++;
                end
                if (o_data.entries_used !== exp_w.entries_used) begin
                    $error("entries_used expected %0d actual %0d",
                           exp_w.entries_used, o_data.entries_used);
                    fail_count++;
                end
            end
        end
    end

    // timeout
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fail_count = 0;
        no_idle = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            blk_start[i] = 0;
            blk_size[i]  = 0;
            blk_free[i]  = 1'b0;
            blk_owner[i] = '0;
        end
        blk_size[0] = MEM_SIZE;
        blk_free[0] = 1'b1;
        blk_count   = 1;
        cur_policy  = POL_FIRST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_table_full();
        test_policy_choice();
        write_policy(POL_BEST);
        test_policy_choice();
        write_policy(POL_WORST);
        test_policy_choice();
        write_policy(POL_RSVD);
        test_policy_choice();

        write_policy(POL_FIRST);
        test_random(360);
        write_policy(POL_BEST);
        test_random(360);
        write_policy(POL_WORST);
        test_random(360);
        write_policy(POL_RSVD);
        test_random(150);
        write_policy(POL_BEST);
        test_random(200);

        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
